### rtl/core/ipq_pkg.sv
// Shared types, constants and lookup functions for the interrupt priority queue.
// Used by ipq_node, interrupt_priority_queue and the testbench; depends on nothing.
package ipq_pkg;

  localparam int SRC_COUNT     = 41;
  localparam int KNOWN_SOURCES = 41;
  localparam int SRC_W         = 6;
  localparam int PRIO_W        = 5;
  localparam int CNT_W         = $clog2(SRC_COUNT + 1);
  localparam int CFG_W         = 16;
  localparam int IDX_W         = 2;
  localparam int VEC_W         = 12;

  typedef logic [SRC_W-1:0]     src_t;
  typedef logic [PRIO_W-1:0]    prio_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SRC_COUNT-1:0] vec_t;

  typedef enum logic [1:0] {
    OP_RAISE  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_REEVAL = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PRIO_A = 2'd0,
    REG_PRIO_B = 2'd1,
    REG_PRIO_C = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] prio_a;
    logic [CFG_W-1:0] prio_b;
    logic [CFG_W-1:0] prio_c;
  } cfg_t;

  // Broadcast to every node: compare operands at acceptance, insert value at update.
  typedef struct packed {
    logic  eval;
    src_t  cmp_src;
    prio_t cmp_pri;
    src_t  ins_src;
  } bcast_t;

  // Per-node load selects for the update cycle.
  typedef struct packed {
    logic take_new;
    logic take_above;
    logic take_below;
  } sel_t;

  // Current priority of a source; unknown sources read as priority zero.
  function automatic prio_t prio_of(input src_t src, input cfg_t cfg);
    prio_t p;
    p = '0;
    if (({1'b0, src} >= 7'(SRC_COUNT)) || ({1'b0, src} >= 7'(KNOWN_SOURCES))) begin
      p = '0;
    end else if (src < 6'd15) begin
      p = 5'd15 - {1'b0, src[3:0]};
    end else if (src == 6'd15) begin
      p = 5'd16;
    end else if (src == 6'd16) begin
      p = {1'b0, cfg.prio_c[3:0]};
    end else if (src == 6'd17) begin
      p = {1'b0, cfg.prio_c[15:12]};
    end else if (src <= 6'd22) begin
      p = {1'b0, cfg.prio_c[11:8]};
    end else if (src == 6'd23) begin
      p = {1'b0, cfg.prio_a[15:12]};
    end else if (src == 6'd24) begin
      p = {1'b0, cfg.prio_a[11:8]};
    end else if (src <= 6'd26) begin
      p = {1'b0, cfg.prio_a[7:4]};
    end else if (src <= 6'd29) begin
      p = {1'b0, cfg.prio_a[3:0]};
    end else if (src <= 6'd33) begin
      p = {1'b0, cfg.prio_b[7:4]};
    end else if (src <= 6'd37) begin
      p = {1'b0, cfg.prio_c[7:4]};
    end else if (src == 6'd38) begin
      p = {1'b0, cfg.prio_b[15:12]};
    end else begin
      p = {1'b0, cfg.prio_b[11:8]};
    end
    return p;
  endfunction

  // Exception vector code of a source.
  function automatic logic [VEC_W-1:0] vector_of(input src_t src);
    logic [VEC_W-1:0] v;
    unique case (src)
      6'd0:  v = 12'h200;
      6'd1:  v = 12'h220;
      6'd2:  v = 12'h240;
      6'd3:  v = 12'h260;
      6'd4:  v = 12'h280;
      6'd5:  v = 12'h2A0;
      6'd6:  v = 12'h2C0;
      6'd7:  v = 12'h2E0;
      6'd8:  v = 12'h300;
      6'd9:  v = 12'h320;
      6'd10: v = 12'h340;
      6'd11: v = 12'h360;
      6'd12: v = 12'h380;
      6'd13: v = 12'h3A0;
      6'd14: v = 12'h3C0;
      6'd15: v = 12'h1C0;
      6'd16: v = 12'h600;
      6'd17: v = 12'h620;
      6'd18: v = 12'h640;
      6'd19: v = 12'h660;
      6'd20: v = 12'h680;
      6'd21: v = 12'h6A0;
      6'd22: v = 12'h6C0;
      6'd23: v = 12'h400;
      6'd24: v = 12'h420;
      6'd25: v = 12'h440;
      6'd26: v = 12'h460;
      6'd27: v = 12'h480;
      6'd28: v = 12'h4A0;
      6'd29: v = 12'h4C0;
      6'd30: v = 12'h4E0;
      6'd31: v = 12'h500;
      6'd32: v = 12'h520;
      6'd33: v = 12'h540;
      6'd34: v = 12'h700;
      6'd35: v = 12'h720;
      6'd36: v = 12'h740;
      6'd37: v = 12'h760;
      6'd38: v = 12'h560;
      6'd39: v = 12'h580;
      6'd40: v = 12'h5A0;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Bit reversal of a node vector, so that a highest-set search becomes a lowest-set one.
  function automatic vec_t bit_rev(input vec_t v);
    vec_t r;
    r = '0;
    for (int i = 0; i < SRC_COUNT; i++) begin
      r[i] = v[SRC_COUNT-1-i];
    end
    return r;
  endfunction

endpackage

### rtl/core/ipq_node.sv
// One node of the queue: holds one pending source, compares it against a broadcast
// source at acceptance and loads from itself, its neighbors or the broadcast on update.
// Depends on ipq_pkg.
module ipq_node (
  input  logic           clk,
  input  ipq_pkg::cfg_t  cfg,
  input  ipq_pkg::bcast_t bc,
  input  logic           occ,
  input  ipq_pkg::sel_t  sel,
  input  ipq_pkg::src_t  from_above,
  input  ipq_pkg::src_t  from_below,
  output ipq_pkg::src_t  entry,
  output ipq_pkg::prio_t prio,
  output logic           hit_match,
  output logic           hit_brk
);

  assign prio = ipq_pkg::prio_of(entry, cfg);

  // Compare results are held for the update cycle.
  always_ff @(posedge clk) begin
    if (bc.eval) begin
      hit_match <= occ && (entry == bc.cmp_src);
      hit_brk   <= occ && ((prio > bc.cmp_pri) ||
                           ((prio == bc.cmp_pri) && (entry < bc.cmp_src)));
    end
  end

  always_ff @(posedge clk) begin
    priority if (sel.take_new) begin
      entry <= bc.ins_src;
    end else if (sel.take_above) begin
      entry <= from_above;
    end else if (sel.take_below) begin
      entry <= from_below;
    end
  end

endmodule

### rtl/core/interrupt_priority_queue.sv
// Top level of the interrupt priority queue: configuration registers, the row of
// queue nodes and the update and result logic. Depends on ipq_pkg and ipq_node.
//
// In the cycle that ends with the start transfer, every node compares its stored source
// with the commanded one in parallel; in the next cycle the node row is updated in one
// step (insert shifts entries away from the top, clear shifts them toward it), the
// pending count and the request flag are updated, and busy is high during that cycle.
// The result is then shown for exactly one cycle with done high, and the receiver
// cannot stall it. A new command can be transferred in that same cycle, but none while
// busy is high. Every command gives exactly one result, also a command that changes
// nothing. The priority words may be written only while the block is idle.
module interrupt_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ipq_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ipq_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [5:0]                  source_index,
  input  logic                        cpu_block,
  input  logic [3:0]                  cpu_mask_level,
  output logic                        done,
  output logic                        irq_request,
  output logic [11:0]                 top_vector,
  output logic                        queue_empty,
  output logic [5:0]                  pending_total
);

  localparam int N = ipq_pkg::SRC_COUNT;

  ipq_pkg::cfg_t  cfg;
  ipq_pkg::cnt_t  count;
  ipq_pkg::cnt_t  count_next;
  logic           request_flag;
  logic           request_flag_next;
  logic           s1_valid;

  // Command held for the update cycle.
  logic [1:0]     s1_op;
  ipq_pkg::src_t  s1_src;
  ipq_pkg::prio_t s1_pri;
  logic           s1_block;
  logic [3:0]     s1_mask;
  ipq_pkg::prio_t s1_prio0;
  ipq_pkg::prio_t s1_prio1;

  logic            accept;
  ipq_pkg::prio_t  in_pri;
  ipq_pkg::bcast_t bc;

  ipq_pkg::src_t  entry_v [N];
  ipq_pkg::prio_t prio_v  [N];
  ipq_pkg::vec_t  match_v;
  ipq_pkg::vec_t  brk_v;
  ipq_pkg::vec_t  occ_v;

  ipq_pkg::vec_t  brk_r;
  ipq_pkg::vec_t  brk_low_r;
  ipq_pkg::vec_t  above_kb;
  ipq_pkg::vec_t  match_low;
  ipq_pkg::vec_t  ge_hit;
  logic           any_brk;
  logic           dup;
  logic           found;
  logic           ins_ok;
  logic           del_ok;
  ipq_pkg::cnt_t  count_dec;
  ipq_pkg::prio_t clr_top_pri;

  assign accept = start && !busy;
  assign busy   = s1_valid;
  assign in_pri = ipq_pkg::prio_of(source_index, cfg);

  assign bc.eval    = accept;
  assign bc.cmp_src = source_index;
  assign bc.cmp_pri = in_pri;
  assign bc.ins_src = s1_src;

  // Node k holds the k-th entry counted down from the top of the queue.
  for (genvar k = 0; k < N; k++) begin : g_node
    ipq_pkg::sel_t sel;
    ipq_pkg::src_t above_val;
    ipq_pkg::src_t below_val;

    assign occ_v[k] = count > ipq_pkg::cnt_t'(k);

    if (k == 0) begin : g_first
      assign above_val      = '0;
      assign sel.take_new   = ins_ok && above_kb[k];
      assign sel.take_above = 1'b0;
    end else begin : g_rest
      assign above_val      = entry_v[k-1];
      assign sel.take_new   = ins_ok && above_kb[k] && !above_kb[k-1];
      assign sel.take_above = ins_ok && above_kb[k] && above_kb[k-1];
    end

    if (k == N - 1) begin : g_last
      assign below_val      = '0;
      assign sel.take_below = 1'b0;
    end else begin : g_inner
      assign below_val      = entry_v[k+1];
      assign sel.take_below = del_ok && ge_hit[k];
    end

    ipq_node u_node (
      .clk        (clk),
      .cfg        (cfg),
      .bc         (bc),
      .occ        (occ_v[k]),
      .sel        (sel),
      .from_above (above_val),
      .from_below (below_val),
      .entry      (entry_v[k]),
      .prio       (prio_v[k]),
      .hit_match  (match_v[k]),
      .hit_brk    (brk_v[k])
    );
  end

  // An insert scans from the bottom of the queue: the breaking entry is the
  // occupied node nearest the bottom whose entry ranks above the new source.
  // Only entries below it count when looking for a duplicate. A clear takes the
  // occurrence nearest the top.
  always_comb begin
    brk_r     = ipq_pkg::bit_rev(brk_v);
    brk_low_r = brk_r & (~brk_r + 1'b1);
    above_kb  = ipq_pkg::bit_rev(brk_low_r - 1'b1);
    any_brk   = |brk_v;
    dup       = |(match_v & above_kb);

    match_low = match_v & (~match_v + 1'b1);
    ge_hit    = ~(match_low - 1'b1);
    found     = |match_v;

    ins_ok = s1_valid && (s1_op == ipq_pkg::OP_RAISE) && (s1_pri != '0) &&
             (count < ipq_pkg::cnt_t'(N)) && !dup;
    del_ok = s1_valid && (s1_op == ipq_pkg::OP_CLEAR) && found;

    count_dec   = count - 1'b1;
    clr_top_pri = match_low[0] ? s1_prio1 : s1_prio0;

    count_next        = count;
    request_flag_next = request_flag;
    if (s1_valid) begin
      unique case (s1_op)
        ipq_pkg::OP_RAISE: begin
          if (ins_ok) begin
            count_next = count + 1'b1;
            // A raise only ever sets the flag, and only when the new source lands on top.
            if (!any_brk && !s1_block && ({1'b0, s1_mask} < s1_pri)) begin
              request_flag_next = 1'b1;
            end
          end
        end
        ipq_pkg::OP_CLEAR: begin
          if (del_ok) begin
            count_next        = count_dec;
            request_flag_next = (count_dec != '0) && !s1_block &&
                                ({1'b0, s1_mask} < clr_top_pri);
          end
        end
        ipq_pkg::OP_REEVAL: begin
          request_flag_next = (count != '0) && !s1_block && ({1'b0, s1_mask} < s1_prio0);
        end
        default: begin
          count_next        = count;
          request_flag_next = request_flag;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg          <= '0;
      count        <= '0;
      request_flag <= 1'b0;
      s1_valid     <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ipq_pkg::REG_PRIO_A: cfg.prio_a <= cfg_data;
          ipq_pkg::REG_PRIO_B: cfg.prio_b <= cfg_data;
          ipq_pkg::REG_PRIO_C: cfg.prio_c <= cfg_data;
          default: cfg <= cfg;
        endcase
      end
      count        <= count_next;
      request_flag <= request_flag_next;
      s1_valid     <= accept;
      done         <= s1_valid;
    end
  end

  // Command capture; the top two priorities are needed to decide the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= opcode;
      s1_src   <= source_index;
      s1_pri   <= in_pri;
      s1_block <= cpu_block;
      s1_mask  <= cpu_mask_level;
      s1_prio0 <= prio_v[0];
      s1_prio1 <= prio_v[1];
    end
  end

  // The result is read straight from the updated state while done is high.
  assign irq_request   = request_flag;
  assign top_vector    = (count != '0) ? ipq_pkg::vector_of(entry_v[0]) : '0;
  assign queue_empty   = (count == '0);
  assign pending_total = 6'(count);

endmodule

### rtl/core/ipq_checker.sv
// Port-level checks for the interrupt priority queue and the bind that attaches them.
// Depends on interrupt_priority_queue's port list.
module ipq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        irq_request,
  input logic [11:0] top_vector,
  input logic        queue_empty,
  input logic [5:0]  pending_total
);

  // Every command transfer is followed by its result with done high.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("command transfer without a result two cycles later");

  // Busy lasts a single cycle per command.
  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // Empty flag agrees with the pending count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (queue_empty == (pending_total == 6'd0)))
    else $error("empty flag disagrees with pending count");

  // An empty queue never requests and has no vector.
  a_empty_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && queue_empty) |-> (!irq_request && (top_vector == 12'd0)))
    else $error("empty queue shows a request or a vector");

endmodule

bind interrupt_priority_queue ipq_checker u_ipq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .irq_request   (irq_request),
  .top_vector    (top_vector),
  .queue_empty   (queue_empty),
  .pending_total (pending_total)
);

### tb/interrupt_priority_queue_tb.sv
// Self-checking testbench for interrupt_priority_queue: directed and random raise, clear
// and re-evaluate commands, each checked against an in-bench model of the pending queue.
// Depends on ipq_pkg and the interrupt_priority_queue RTL; needs no files or arguments.
module interrupt_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog gives up once this limit of quiet cycles passes without a transfer or a
  // result. The longest correct stretch is a long sender gap plus a drain, far below this.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles that are let pass after the last result before the block is treated as idle.
  localparam int DRAIN_CYCLES   = 4;
  // The opcode that the block does not define; it must leave the queue untouched.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Vector code of each known source, in source table order.
  localparam logic [11:0] SRC_VECTOR [0:ipq_pkg::SRC_COUNT-1] = '{
    12'h200, 12'h220, 12'h240, 12'h260, 12'h280, 12'h2A0, 12'h2C0, 12'h2E0,
    12'h300, 12'h320, 12'h340, 12'h360, 12'h380, 12'h3A0, 12'h3C0, 12'h1C0,
    12'h600, 12'h620, 12'h640, 12'h660, 12'h680, 12'h6A0, 12'h6C0, 12'h400,
    12'h420, 12'h440, 12'h460, 12'h480, 12'h4A0, 12'h4C0, 12'h4E0, 12'h500,
    12'h520, 12'h540, 12'h700, 12'h720, 12'h740, 12'h760, 12'h560, 12'h580,
    12'h5A0
  };

  // What the block reports after one command.
  typedef struct packed {
    logic        irq;
    logic [11:0] vec;
    logic        empty;
    logic [5:0]  total;
  } irq_status_t;

  // Every input starts at a known value; reset is high from time zero.
  logic                      clk            = 1'b0;
  logic                      rst            = 1'b1;
  logic                      cfg_write      = 1'b0;
  logic [ipq_pkg::IDX_W-1:0] cfg_index      = '0;
  logic [ipq_pkg::CFG_W-1:0] cfg_data       = '0;
  logic                      start          = 1'b0;
  logic [1:0]                opcode         = '0;
  logic [5:0]                source_index   = '0;
  logic                      cpu_block      = 1'b0;
  logic [3:0]                cpu_mask_level = '0;
  logic                      busy;
  logic                      done;
  logic                      irq_request;
  logic [11:0]               top_vector;
  logic                      queue_empty;
  logic [5:0]                pending_total;

  // Model state: the priority words as last written, the pending list (bottom at
  // index 0, top at queued_cnt-1) and the request flag.
  logic [15:0]      prio_a = '0;
  logic [15:0]      prio_b = '0;
  logic [15:0]      prio_c = '0;
  logic [5:0]       queued_src [0:ipq_pkg::SRC_COUNT-1];
  int               queued_cnt  = 0;
  logic             irq_pending = 1'b0;

  // Status words predicted at each start transfer, oldest first.
  irq_status_t      expected_status [$];
  irq_status_t      want;
  int               errors      = 0;
  int               idle_cycles = 0;

  interrupt_priority_queue dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .source_index   (source_index),
    .cpu_block      (cpu_block),
    .cpu_mask_level (cpu_mask_level),
    .done           (done),
    .irq_request    (irq_request),
    .top_vector     (top_vector),
    .queue_empty    (queue_empty),
    .pending_total  (pending_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------------

  // Current priority of a source. Sources at or past the table end have priority zero,
  // which a raise treats as disabled.
  function automatic logic [4:0] src_priority(input logic [5:0] src);
    int s;
    s = int'(src);
    if (s >= ipq_pkg::SRC_COUNT) return 5'd0;
    if (s < 15) return 5'(15 - s);
    if (s == 15) return 5'd16;
    if (s == 16) return {1'b0, prio_c[3:0]};
    if (s == 17) return {1'b0, prio_c[15:12]};
    if (s <= 22) return {1'b0, prio_c[11:8]};
    if (s == 23) return {1'b0, prio_a[15:12]};
    if (s == 24) return {1'b0, prio_a[11:8]};
    if (s <= 26) return {1'b0, prio_a[7:4]};
    if (s <= 29) return {1'b0, prio_a[3:0]};
    if (s <= 33) return {1'b0, prio_b[7:4]};
    if (s <= 37) return {1'b0, prio_c[7:4]};
    if (s == 38) return {1'b0, prio_b[15:12]};
    return {1'b0, prio_b[11:8]};
  endfunction

  // The request follows the top entry, judged by its priority as configured now.
  function automatic void update_request(input logic blk, input logic [3:0] mask);
    irq_pending = 1'b0;
    if (queued_cnt > 0) begin
      if (!blk && ({1'b0, mask} < src_priority(queued_src[queued_cnt-1]))) begin
        irq_pending = 1'b1;
      end
    end
  endfunction

  // Insert by priority; among equal priorities the lower index sits nearer the top.
  // The walk stops at the first entry that outranks the new source, so a source whose
  // priority moved while it was queued can end up in the list twice.
  function automatic void raise_pending(input logic [5:0] src, input logic blk,
                                        input logic [3:0] mask);
    logic [4:0] pri;
    logic [4:0] cp;
    int         pos;
    pri = src_priority(src);
    if (pri == 5'd0 || queued_cnt >= ipq_pkg::SRC_COUNT) return;
    pos = queued_cnt;
    for (int i = 0; i < queued_cnt; i++) begin
      cp = src_priority(queued_src[i]);
      if (queued_src[i] == src) return;
      if (cp > pri || (cp == pri && queued_src[i] < src)) begin
        pos = i;
        break;
      end
    end
    for (int j = queued_cnt; j > pos; j--) begin
      queued_src[j] = queued_src[j-1];
    end
    queued_src[pos] = src;
    // Only a source that lands on top can set the request; it never drops it.
    if (pos == queued_cnt && !blk && ({1'b0, mask} < pri)) irq_pending = 1'b1;
    queued_cnt++;
  endfunction

  // Remove the topmost copy of a source; a source that is not queued changes nothing.
  function automatic void clear_pending(input logic [5:0] src, input logic blk,
                                        input logic [3:0] mask);
    for (int i = queued_cnt - 1; i >= 0; i--) begin
      if (queued_src[i] == src) begin
        for (int k = i; k < queued_cnt - 1; k++) begin
          queued_src[k] = queued_src[k+1];
        end
        queued_cnt--;
        update_request(blk, mask);
        return;
      end
    end
  endfunction

  function automatic irq_status_t predict_status(input logic [1:0] op, input logic [5:0] src,
                                                 input logic blk, input logic [3:0] mask);
    irq_status_t st;
    unique case (op)
      ipq_pkg::OP_RAISE:  raise_pending(src, blk, mask);
      ipq_pkg::OP_CLEAR:  clear_pending(src, blk, mask);
      ipq_pkg::OP_REEVAL: update_request(blk, mask);
      default: begin
      end
    endcase
    st.irq   = irq_pending;
    st.vec   = (queued_cnt > 0) ? SRC_VECTOR[queued_src[queued_cnt-1]] : 12'h000;
    st.empty = (queued_cnt == 0);
    st.total = 6'(queued_cnt);
    return st;
  endfunction

  // ---------------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mask levels lean on both extremes, where the comparison with priority is tight.
  function automatic logic [3:0] pick_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 4'd0;
    if (r < 30) return 4'd15;
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic pick_block();
    return ($urandom_range(0, 4) == 0);
  endfunction

  // A priority word; in sparse mode about a quarter of the fields disable their sources.
  function automatic logic [15:0] rand_prio_word(input bit sparse);
    logic [15:0] w;
    for (int i = 0; i < 4; i++) begin
      if (sparse && $urandom_range(0, 3) == 0) w[4*i +: 4] = 4'd0;
      else w[4*i +: 4] = 4'($urandom_range(0, 15));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------------

  // Present one command and hold it until the block takes it, then predict its status.
  // Start is left high when the next command follows at once, so it is never lowered
  // and raised in the same time step.
  task automatic send_cmd(input logic [1:0] op, input logic [5:0] src, input logic blk,
                          input logic [3:0] mask, input int gap);
    start          <= 1'b1;
    opcode         <= op;
    source_index   <= src;
    cpu_block      <= blk;
    cpu_mask_level <= mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_status.push_back(predict_status(op, src, blk, mask));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every predicted status has come back, plus a few cycles.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The priority words are written only with the block idle.
  task automatic write_prio_words(input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] c);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_index <= ipq_pkg::REG_PRIO_A;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= ipq_pkg::REG_PRIO_B;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= ipq_pkg::REG_PRIO_C;
    cfg_data  <= c;
    @(posedge clk);
    cfg_write <= 1'b0;
    prio_a = a;
    prio_b = b;
    prio_c = c;
  endtask

  // Clear whatever is queued, in random order, until the model says the list is empty.
  task automatic flush_queue();
    int pick;
    while (queued_cnt > 0) begin
      pick = $urandom_range(0, queued_cnt - 1);
      send_cmd(ipq_pkg::OP_CLEAR, queued_src[pick], pick_block(), pick_mask(),
               pick_gap(1'b0));
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Fixed sources only: every configurable source is disabled by zero priority words.
  task automatic test_fixed_sources();
    write_prio_words(16'h0000, 16'h0000, 16'h0000);
    send_cmd(ipq_pkg::OP_RAISE,  6'd14, 1'b0, 4'd0,  pick_gap(1'b0)); // lowest fixed priority
    send_cmd(ipq_pkg::OP_RAISE,  6'd15, 1'b1, 4'd0,  pick_gap(1'b0)); // top but blocked: flag kept
    send_cmd(ipq_pkg::OP_RAISE,  6'd0,  1'b0, 4'd0,  pick_gap(1'b0)); // lands below the top
    send_cmd(ipq_pkg::OP_REEVAL, 6'd0,  1'b1, 4'd0,  pick_gap(1'b0)); // block drops the request
    send_cmd(ipq_pkg::OP_REEVAL, 6'd63, 1'b0, 4'd15, pick_gap(1'b0)); // mask 15 still below 16
    send_cmd(ipq_pkg::OP_RAISE,  6'd15, 1'b0, 4'd0,  pick_gap(1'b0)); // already queued
    send_cmd(ipq_pkg::OP_RAISE,  6'd16, 1'b0, 4'd0,  pick_gap(1'b0)); // priority zero
    send_cmd(ipq_pkg::OP_RAISE,  6'd63, 1'b0, 4'd0,  pick_gap(1'b0)); // past the table
    send_cmd(ipq_pkg::OP_RAISE,  6'd41, 1'b0, 4'd0,  pick_gap(1'b0)); // first index past the table
    send_cmd(ipq_pkg::OP_CLEAR,  6'd40, 1'b0, 4'd0,  pick_gap(1'b0)); // not queued
    send_cmd(OP_UNUSED,          6'd63, 1'b1, 4'd15, pick_gap(1'b0)); // undefined opcode
    send_cmd(ipq_pkg::OP_CLEAR,  6'd15, 1'b0, 4'd15, pick_gap(1'b0)); // new top at 15, mask 15
    send_cmd(ipq_pkg::OP_CLEAR,  6'd0,  1'b0, 4'd0,  pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_CLEAR,  6'd14, 1'b0, 4'd0,  pick_gap(1'b0)); // queue becomes empty
    send_cmd(ipq_pkg::OP_CLEAR,  6'd14, 1'b0, 4'd0,  pick_gap(1'b0)); // clear on an empty queue
  endtask

  // With all words at their maximum, sources 16..40 tie with source 0 at priority 15.
  task automatic test_equal_priority();
    write_prio_words(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(ipq_pkg::OP_RAISE,  6'd26, 1'b0, 4'd14, pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_RAISE,  6'd25, 1'b0, 4'd14, pick_gap(1'b0)); // lower index goes above 26
    send_cmd(ipq_pkg::OP_RAISE,  6'd0,  1'b1, 4'd0,  pick_gap(1'b0)); // lowest index on top
    send_cmd(ipq_pkg::OP_RAISE,  6'd40, 1'b0, 4'd0,  pick_gap(1'b0)); // highest index at the bottom
    send_cmd(ipq_pkg::OP_REEVAL, 6'd0,  1'b0, 4'd15, pick_gap(1'b0)); // mask equals priority
    send_cmd(ipq_pkg::OP_CLEAR,  6'd0,  1'b0, 4'd0,  pick_gap(1'b0));
  endtask

  // Priorities are rewritten under queued sources: order stays, the checks follow
  // the new values, and a source that dropped to zero can still be cleared.
  task automatic test_priority_change();
    write_prio_words(16'h1111, 16'h0000, 16'hFFFF);
    send_cmd(ipq_pkg::OP_REEVAL, 6'd0,  1'b0, 4'd0, pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_REEVAL, 6'd0,  1'b0, 4'd1, pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_RAISE,  6'd26, 1'b0, 4'd0, pick_gap(1'b0)); // still found in the list
    send_cmd(ipq_pkg::OP_RAISE,  6'd24, 1'b0, 4'd0, pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_CLEAR,  6'd40, 1'b0, 4'd0, pick_gap(1'b0));
  endtask

  // Mostly raises of known sources and clears of queued ones with random content; the
  // rest is re-evaluation and noise: unknown sources, stray clears, the undefined opcode.
  task automatic test_random_traffic(input int n_items, input int raise_pct,
                                     input bit no_idle);
    int         r;
    logic [1:0] op;
    logic [5:0] src;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < raise_pct) begin
        op  = ipq_pkg::OP_RAISE;
        src = 6'($urandom_range(0, ipq_pkg::SRC_COUNT - 1));
      end else if (r < 80) begin
        op = ipq_pkg::OP_CLEAR;
        if (queued_cnt > 0 && $urandom_range(0, 4) != 0) begin
          src = queued_src[$urandom_range(0, queued_cnt - 1)];
        end else begin
          src = 6'($urandom_range(0, 63));
        end
      end else if (r < 90) begin
        op  = ipq_pkg::OP_REEVAL;
        src = 6'($urandom_range(0, 63));
      end else if (r < 96) begin
        op  = ($urandom_range(0, 1) == 1) ? ipq_pkg::OP_RAISE : ipq_pkg::OP_CLEAR;
        src = 6'($urandom_range(ipq_pkg::SRC_COUNT, 63));
      end else begin
        op  = OP_UNUSED;
        src = 6'($urandom_range(0, 63));
      end
      send_cmd(op, src, pick_block(), pick_mask(), pick_gap(no_idle));
      // Now and then the sender holds off until the block has answered everything.
      if (!no_idle && $urandom_range(0, 99) == 0) wait_for_results();
    end
  endtask

  // Fill every slot, then force a duplicate entry through a priority change so that a
  // raise meets a full queue, and empty the list again.
  task automatic test_full_queue();
    logic [5:0] order [0:ipq_pkg::SRC_COUNT-1];
    logic [5:0] tmp;
    int         j;
    write_prio_words(16'hFFFF, 16'hFFFF, 16'hFFFF);
    flush_queue();
    for (int i = 0; i < ipq_pkg::SRC_COUNT; i++) order[i] = 6'(i);
    for (int i = ipq_pkg::SRC_COUNT - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < ipq_pkg::SRC_COUNT; i++) begin
      send_cmd(ipq_pkg::OP_RAISE, order[i], pick_block(), pick_mask(), pick_gap(1'b0));
    end
    send_cmd(ipq_pkg::OP_RAISE, 6'($urandom_range(0, ipq_pkg::SRC_COUNT - 1)), 1'b0, 4'd0,
             pick_gap(1'b0));
    // Sources 16..22 and 34..37 drop to priority 1 while queued.
    write_prio_words(16'hFFFF, 16'hFFFF, 16'h1111);
    send_cmd(ipq_pkg::OP_REEVAL, 6'd0,  1'b0, 4'd0, pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_RAISE,  6'd16, 1'b0, 4'd0, pick_gap(1'b0)); // full: ignored
    send_cmd(ipq_pkg::OP_CLEAR,  6'd3,  1'b0, 4'd0, pick_gap(1'b0));
    send_cmd(ipq_pkg::OP_RAISE,  6'd16, 1'b0, 4'd0, pick_gap(1'b0)); // second copy of 16
    send_cmd(ipq_pkg::OP_RAISE,  6'd3,  1'b0, 4'd0, pick_gap(1'b0)); // full again: ignored
    send_cmd(ipq_pkg::OP_CLEAR,  6'd16, 1'b0, 4'd0, pick_gap(1'b0));
    flush_queue();
  endtask

  // ---------------------------------------------------------------------------------
  // Result checking: each done cycle is compared with the oldest prediction.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_status.size() == 0) begin
        $error("result with no command waiting: top_vector %h, pending_total %0d",
               top_vector, pending_total);
        errors++;
      end else begin
        want = expected_status.pop_front();
        if (irq_request !== want.irq) begin
          $error("irq_request: expected %0b, actual %0b", want.irq, irq_request);
          errors++;
        end
        if (top_vector !== want.vec) begin
          $error("top_vector: expected %h, actual %h", want.vec, top_vector);
          errors++;
        end
        if (queue_empty !== want.empty) begin
          $error("queue_empty: expected %0b, actual %0b", want.empty, queue_empty);
          errors++;
        end
        if (pending_total !== want.total) begin
          $error("pending_total: expected %0d, actual %0d", want.total, pending_total);
          errors++;
        end
      end
    end
  end

  // Watchdog: any start transfer or result resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fixed_sources();
    test_equal_priority();
    test_priority_change();

    // Each phase keeps whatever is still queued, so priorities also change under
    // pending sources at the boundaries where anything is still queued.
    write_prio_words(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(210, 60, 1'b0);
    write_prio_words(rand_prio_word(1'b0), rand_prio_word(1'b0), rand_prio_word(1'b0));
    test_random_traffic(210, 40, 1'b0);
    write_prio_words(16'h0000, 16'h0000, 16'h0000);
    test_random_traffic(210, 30, 1'b1);
    write_prio_words(rand_prio_word(1'b1), rand_prio_word(1'b1), rand_prio_word(1'b1));
    test_random_traffic(210, 55, 1'b0);
    write_prio_words(16'h1111, 16'h1111, 16'h1111);
    test_random_traffic(210, 45, 1'b0);
    test_full_queue();
    write_prio_words(rand_prio_word(1'b1), rand_prio_word(1'b0), rand_prio_word(1'b1));
    test_random_traffic(210, 20, 1'b0);

    // Let every result arrive, then give the block a few more cycles to misbehave.
    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ipq_pkg.sv
rtl/core/ipq_node.sv
rtl/core/interrupt_priority_queue.sv
rtl/core/ipq_checker.sv
tb/interrupt_priority_queue_tb.sv
